@@ sv/eid_pkg.sv @@
// Shared types and constants for the entity id table.
package eid_pkg;

  // Item opcodes (carried on s_tuser)
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SELF_ID    = 2'd0;
  localparam logic [1:0] REG_CREATE_MIN = 2'd1;
  localparam logic [1:0] REG_REMOVE_MIN = 2'd2;

  // Field widths
  localparam int ID_W    = 16;
  localparam int POS_W   = 16;
  localparam int LVL_W   = 16;
  localparam int RAW_W   = 32;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int SLOT_OW = 6;
  localparam int LIVE_OW = 7;

  // Stored record: {self, level, y, x, id}
  localparam int REC_W = 1 + LVL_W + 2 * POS_W + ID_W;

  // Level saturation value
  localparam logic [LVL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Port word widths
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } eid_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic apply;
  } eid_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } eid_status_t;

endpackage

@@ sv/entity_id_table_core.sv @@
// Entity id table: top level joining sequencer and datapath.
// Create and remove items that pass the length check scan the record RAM, one read
// per entry, before the result word is written; clear, opcode 3 and short items skip the scan.
// The result is applied only once the output register is free; the next item is taken
// while the previous result still waits on the output.
// Reset (rst, synchronous): table empty, counters, dirty mark and config registers at zero.
module entity_id_table_core
  import eid_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // entity_id, pos_x, pos_y, level_raw, packet_length
  input  logic [S_DATA_W-1:0] s_tdata,
  // opcode
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // accepted, slot_index, live_count, created_total, removed_total, changed_flag
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  eid_cmd_t    cmd;
  eid_status_t status;

  eid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eid_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ sv/eid_ram.sv @@
// Generic single write port RAM with registered read.
module eid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/eid_ctrl.sv @@
// Sequencer for the entity id table: accept, scan, apply.
module eid_ctrl
  import eid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  eid_status_t status,
  output eid_cmd_t    cmd
);

  eid_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.scan_init = 1'b1;
        state_next    = status.need_scan ? ST_SCAN : ST_APPLY;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read word is evaluated here
      ST_DRAIN: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (status.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/eid_dp.sv @@
// Datapath: item and config registers, record RAM, scan, counters, result word.
module eid_dp
  import eid_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  eid_cmd_t            cmd,
  output eid_status_t         status
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Configuration
  logic [CFG_W-1:0] self_id, create_min, remove_min;

  // Latched item
  logic [1:0]       item_op;
  logic [ID_W-1:0]  item_id;
  logic [POS_W-1:0] item_x, item_y;
  logic [LVL_W-1:0] item_level;
  logic             item_len_ok;

  // Table state
  logic [ENTRIES-1:0] live;
  logic [CW-1:0]      live_cnt, live_cnt_next;
  logic [CNT_W-1:0]   created, created_next;
  logic [CNT_W-1:0]   removed, removed_next;
  logic               dirty, dirty_next;

  // Scan
  logic [AW-1:0]    scan_addr, addr_d;
  logic             rd_valid;
  logic [REC_W-1:0] rd_rec;
  logic             found, free_found;
  logic [AW-1:0]    match_slot, free_slot;

  // Apply
  logic             create_ok, remove_ok, res_ok;
  logic [AW-1:0]    tgt_slot, res_slot;
  logic             item_self;
  logic [REC_W-1:0] wr_rec;

  // Result word
  logic               res_valid;
  logic [M_DATA_W-1:0] res_word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id    <= '0;
      create_min <= '0;
      remove_min <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SELF_ID:    self_id    <= cfg_data;
        REG_CREATE_MIN: create_min <= cfg_data;
        REG_REMOVE_MIN: remove_min <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture; length check and level clamp done on the way in
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op    <= s_tuser;
      item_id    <= s_tdata[15:0];
      item_x     <= s_tdata[31:16];
      item_y     <= s_tdata[47:32];
      item_level <= (|s_tdata[79:64]) ? LEVEL_MAX : s_tdata[63:48];
      if (s_tuser == OP_CREATE) begin
        item_len_ok <= s_tdata[95:80] >= create_min;
      end else begin
        item_len_ok <= s_tdata[95:80] >= remove_min;
      end
    end
  end

  // Record store
  assign item_self = (self_id != '0) && (item_id == self_id);
  assign wr_rec    = {item_self, item_level, item_y, item_x, item_id};

  eid_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (create_ok & cmd.apply),
    .waddr (tgt_slot),
    .wdata (wr_rec),
    .raddr (scan_addr),
    .rdata (rd_rec)
  );

  // Scan: address issue, then first-match and first-free search on the read word
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_addr  <= '0;
    end else if (cmd.scan_init) begin
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_addr  <= '0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.scan_step) begin
        scan_addr <= scan_addr + AW'(1);
      end
      if (rd_valid) begin
        if (!found && live[addr_d] && (rd_rec[ID_W-1:0] == item_id)) begin
          found <= 1'b1;
        end
        if (!free_found && !live[addr_d]) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_d <= scan_addr;
    if (rd_valid && !found && live[addr_d] && (rd_rec[ID_W-1:0] == item_id)) begin
      match_slot <= addr_d;
    end
    if (rd_valid && !free_found && !live[addr_d]) begin
      free_slot <= addr_d;
    end
  end

  assign status.need_scan = item_len_ok &&
                            ((item_op == OP_CREATE) || (item_op == OP_REMOVE));
  assign status.scan_last = (scan_addr == AW'(ENTRIES - 1));
  assign status.out_free  = !res_valid || m_tready;

  // Decision and next counter values
  assign create_ok = (item_op == OP_CREATE) && item_len_ok && (found || free_found);
  assign remove_ok = (item_op == OP_REMOVE) && item_len_ok && found;
  assign tgt_slot  = found ? match_slot : free_slot;

  always_comb begin
    live_cnt_next = live_cnt;
    created_next  = created;
    removed_next  = removed;
    dirty_next    = dirty;
    res_ok        = 1'b0;
    res_slot      = '0;
    priority if (item_op == OP_CLEAR) begin
      live_cnt_next = '0;
      created_next  = '0;
      removed_next  = '0;
      dirty_next    = 1'b0;
      res_ok        = 1'b1;
    end else if (create_ok) begin
      if (!found) begin
        live_cnt_next = live_cnt + CW'(1);
        created_next  = created + CNT_W'(1);
      end
      dirty_next = 1'b1;
      res_ok     = 1'b1;
      res_slot   = tgt_slot;
    end else if (remove_ok) begin
      live_cnt_next = live_cnt - CW'(1);
      removed_next  = removed + CNT_W'(1);
      dirty_next    = 1'b1;
      res_ok        = 1'b1;
      res_slot      = match_slot;
    end else begin
      res_ok = 1'b0;
    end
  end

  // Table state update
  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      live_cnt <= '0;
      created  <= '0;
      removed  <= '0;
      dirty    <= 1'b0;
    end else if (cmd.apply) begin
      live_cnt <= live_cnt_next;
      created  <= created_next;
      removed  <= removed_next;
      dirty    <= dirty_next;
      priority if (item_op == OP_CLEAR) begin
        live <= '0;
      end else if (create_ok) begin
        live[tgt_slot] <= 1'b1;
      end else if (remove_ok) begin
        live[match_slot] <= 1'b0;
      end else begin
        live <= live;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.apply) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_word <= {1'b0, dirty_next, removed_next, created_next,
                   LIVE_OW'(live_cnt_next), SLOT_OW'(res_slot), res_ok};
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = res_word;

endmodule

@@ sv/eid_checker.sv @@
// Port-level checks for the entity id table, bound to the top level.
module eid_checker
  import eid_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // No result word straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

  // Rejected items report slot zero
  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
    else $error("nonzero slot on rejected item");

  // Live count never exceeds the table size
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[13:7]) <= 32'(ENTRIES))
    else $error("live count above table size");

endmodule

bind entity_id_table_core eid_checker #(.ENTRIES(ENTRIES)) u_eid_checker (.*);
